>>> rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants for the nearest-neighbour scaler with
// RGB565 output conversion.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Field widths
  localparam int unsigned PixInW   = 32;
  localparam int unsigned PixOutW  = 16;
  localparam int unsigned DimW     = 12;   // output sizes, counters
  localparam int unsigned CoordW   = 11;   // origins, source coordinates
  localparam int unsigned FmtW     = 2;
  localparam int unsigned AccW     = 44;   // row accumulator / row step
  localparam int unsigned FracBits = 32;

  // Configuration port
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgIdxW  = 3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OUT_WIDTH      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OUT_HEIGHT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COL_STEP_WHOLE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COL_STEP_REST  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_ROW_STEP       = 3'd7;

  // Source pixel formats (code 3 is treated as XRGB8888)
  localparam logic [FmtW-1:0] FMT_RGB565   = 2'd0;
  localparam logic [FmtW-1:0] FMT_RGB1555  = 2'd1;
  localparam logic [FmtW-1:0] FMT_XRGB8888 = 2'd2;

  // Register file contents
  typedef struct packed {
    logic [FmtW-1:0]   pixel_format;
    logic [DimW-1:0]   out_width;
    logic [DimW-1:0]   out_height;
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [DimW-1:0]   col_step_whole;
    logic [CoordW-1:0] col_step_rest;
    logic [AccW-1:0]   row_step;
  } cfg_t;

  // Position results of one walk step
  typedef struct packed {
    logic [DimW-1:0]   dest_x;
    logic [DimW-1:0]   dest_y;
    logic [CoordW-1:0] next_src_x;
    logic [CoordW-1:0] next_src_y;
    logic              frame_done;
  } walk_t;

endpackage

>>> rtl/nsc_convert.sv
// ----------------------------------------------------------------------------
// nsc_convert
// Converts one raw source pixel to a 16-bit RGB565 screen pixel.
// ----------------------------------------------------------------------------
module nsc_convert (
  input  logic [nsc_pkg::FmtW-1:0]    fmt,
  input  logic [nsc_pkg::PixInW-1:0]  raw,
  output logic [nsc_pkg::PixOutW-1:0] pixel
);

  always_comb begin
    case (fmt)
      nsc_pkg::FMT_RGB565: begin
        pixel = raw[15:0];
      end
      nsc_pkg::FMT_RGB1555: begin
        // red to bits 15:11, green to 10:6, bit 5 left clear
        pixel = {raw[14:10], raw[9:5], 1'b0, raw[4:0]};
      end
      default: begin
        // XRGB8888: top bits of each channel
        pixel = {raw[23:19], raw[15:10], raw[7:3]};
      end
    endcase
  end

endmodule

>>> rtl/nsc_walker.sv
// ----------------------------------------------------------------------------
// nsc_walker
// Output raster walk: keeps output column/row, the source column as
// whole-plus-remainder and the fixed-point source row accumulator.
// ----------------------------------------------------------------------------
module nsc_walker (
  input  logic           clk,
  input  logic           rst_n,
  input  nsc_pkg::cfg_t  cfg,
  input  logic           step,
  input  logic           start,
  output nsc_pkg::walk_t res
);

  localparam int unsigned DimW = nsc_pkg::DimW;
  localparam int unsigned AccW = nsc_pkg::AccW;

  logic [DimW-1:0] out_col_r, out_col_nxt;
  logic [DimW-1:0] out_row_r, out_row_nxt;
  logic [DimW-1:0] src_col_r, src_col_nxt;
  logic [DimW-1:0] rem_r, rem_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;

  logic [DimW-1:0] col_cur, row_cur, src_cur, rem_cur;
  logic [AccW-1:0] acc_cur;
  logic [DimW:0]   col_inc, row_inc;
  logic            line_end, last;
  logic [DimW-1:0] src_sum, rem_sum;
  logic            rem_wrap;

  // A frame start clears the walk before this item
  always_comb begin
    col_cur = start ? '0 : out_col_r;
    row_cur = start ? '0 : out_row_r;
    src_cur = start ? '0 : src_col_r;
    rem_cur = start ? '0 : rem_r;
    acc_cur = start ? '0 : acc_r;
  end

  // End of line / frame tests
  always_comb begin
    col_inc  = {1'b0, col_cur} + {{DimW{1'b0}}, 1'b1};
    row_inc  = {1'b0, row_cur} + {{DimW{1'b0}}, 1'b1};
    line_end = col_inc >= {1'b0, cfg.out_width};
    last     = line_end && (row_inc >= {1'b0, cfg.out_height});
  end

  // Column step with one remainder correction
  always_comb begin
    src_sum  = src_cur + cfg.col_step_whole;
    rem_sum  = rem_cur + {1'b0, cfg.col_step_rest};
    rem_wrap = rem_sum >= cfg.out_width;
  end

  // Next walk state
  always_comb begin
    if (last) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
      src_col_nxt = '0;
      rem_nxt     = '0;
      acc_nxt     = '0;
    end else if (line_end) begin
      out_col_nxt = '0;
      out_row_nxt = row_inc[DimW-1:0];
      src_col_nxt = '0;
      rem_nxt     = '0;
      acc_nxt     = acc_cur + cfg.row_step;
    end else begin
      out_col_nxt = col_inc[DimW-1:0];
      out_row_nxt = row_cur;
      src_col_nxt = rem_wrap ? src_sum + {{(DimW-1){1'b0}}, 1'b1} : src_sum;
      rem_nxt     = rem_wrap ? rem_sum - cfg.out_width : rem_sum;
      acc_nxt     = acc_cur;
    end
  end

  // Results of this step
  always_comb begin
    res.dest_x     = {1'b0, cfg.origin_x} + col_cur;
    res.dest_y     = {1'b0, cfg.origin_y} + row_cur;
    res.next_src_x = src_col_nxt[nsc_pkg::CoordW-1:0];
    res.next_src_y = acc_nxt[nsc_pkg::FracBits +: nsc_pkg::CoordW];
    res.frame_done = last;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_col_r <= '0;
      out_row_r <= '0;
      src_col_r <= '0;
      rem_r     <= '0;
      acc_r     <= '0;
    end else if (step) begin
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      src_col_r <= src_col_nxt;
      rem_r     <= rem_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

>>> rtl/nearest_scaler_rgb565_convert_unit.sv
// ----------------------------------------------------------------------------
// nearest_scaler_rgb565_convert_unit
// Output-order nearest-neighbour scaler with conversion to RGB565.
//
//   Port group   Dir  Transaction contents
//   in_*         in   source pixel (tdata), start of frame (tuser)
//   out_*        out  pixel, screen x/y, next source x/y (tdata), end of frame
//   cfg_*        in   APB register access, 64-bit data, 8-byte spacing
//
// One pixel per clock while out_tready does not stall: an input register
// feeds the walk/convert logic and a result register; the walk state
// updates as the item leaves the input register.
// Reset is synchronous; the walk restarts at output pixel zero and the
// registers take their default values. A stall on out_tready holds both
// stages; a full input register then drops in_tready combinationally.
// ----------------------------------------------------------------------------
module nearest_scaler_rgb565_convert_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] source_pixel
  input  logic                          in_tuser,   // [0] start_frame
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] out_pixel, [27:16] dest_x, [39:28] dest_y,
  // [50:40] next_src_x, [61:51] next_src_y, [63:62] zero
  output logic [63:0]                   out_tdata,
  output logic                          out_tlast,  // frame_done
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [nsc_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [nsc_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [nsc_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned CfgDataW = nsc_pkg::CfgDataW;

  nsc_pkg::cfg_t cfg_r;

  logic                        in_valid_r;
  logic [nsc_pkg::PixInW-1:0]  in_pixel_r;
  logic                        in_start_r;

  logic                        out_valid_r;
  logic [nsc_pkg::PixOutW-1:0] out_pixel_r;
  nsc_pkg::walk_t              out_walk_r;

  logic                        advance;
  logic                        step;
  logic                        cfg_wr;
  logic [nsc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [nsc_pkg::PixOutW-1:0] conv_pixel;
  nsc_pkg::walk_t              walk;

  // Handshake
  assign advance    = !out_valid_r || out_tready;
  assign step       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;

  // Register access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[nsc_pkg::CfgAddrW-1:nsc_pkg::CfgAddrW-nsc_pkg::CfgIdxW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format   <= nsc_pkg::FMT_RGB565;
      cfg_r.out_width      <= nsc_pkg::DimW'(1);
      cfg_r.out_height     <= nsc_pkg::DimW'(1);
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.col_step_whole <= nsc_pkg::DimW'(1);
      cfg_r.col_step_rest  <= '0;
      cfg_r.row_step       <= nsc_pkg::AccW'(1) << nsc_pkg::FracBits;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nsc_pkg::REG_PIXEL_FORMAT:   cfg_r.pixel_format   <= cfg_pwdata[nsc_pkg::FmtW-1:0];
        nsc_pkg::REG_OUT_WIDTH:      cfg_r.out_width      <= cfg_pwdata[nsc_pkg::DimW-1:0];
        nsc_pkg::REG_OUT_HEIGHT:     cfg_r.out_height     <= cfg_pwdata[nsc_pkg::DimW-1:0];
        nsc_pkg::REG_ORIGIN_X:       cfg_r.origin_x       <= cfg_pwdata[nsc_pkg::CoordW-1:0];
        nsc_pkg::REG_ORIGIN_Y:       cfg_r.origin_y       <= cfg_pwdata[nsc_pkg::CoordW-1:0];
        nsc_pkg::REG_COL_STEP_WHOLE: cfg_r.col_step_whole <= cfg_pwdata[nsc_pkg::DimW-1:0];
        nsc_pkg::REG_COL_STEP_REST:  cfg_r.col_step_rest  <= cfg_pwdata[nsc_pkg::CoordW-1:0];
        nsc_pkg::REG_ROW_STEP:       cfg_r.row_step       <= cfg_pwdata[nsc_pkg::AccW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (cfg_idx)
      nsc_pkg::REG_PIXEL_FORMAT:   cfg_prdata = CfgDataW'(cfg_r.pixel_format);
      nsc_pkg::REG_OUT_WIDTH:      cfg_prdata = CfgDataW'(cfg_r.out_width);
      nsc_pkg::REG_OUT_HEIGHT:     cfg_prdata = CfgDataW'(cfg_r.out_height);
      nsc_pkg::REG_ORIGIN_X:       cfg_prdata = CfgDataW'(cfg_r.origin_x);
      nsc_pkg::REG_ORIGIN_Y:       cfg_prdata = CfgDataW'(cfg_r.origin_y);
      nsc_pkg::REG_COL_STEP_WHOLE: cfg_prdata = CfgDataW'(cfg_r.col_step_whole);
      nsc_pkg::REG_COL_STEP_REST:  cfg_prdata = CfgDataW'(cfg_r.col_step_rest);
      nsc_pkg::REG_ROW_STEP:       cfg_prdata = CfgDataW'(cfg_r.row_step);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_pixel_r <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  // Datapath
  nsc_convert u_convert (
    .fmt   (cfg_r.pixel_format),
    .raw   (in_pixel_r),
    .pixel (conv_pixel)
  );

  nsc_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (step),
    .start (in_start_r),
    .res   (walk)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_pixel_r <= conv_pixel;
      out_walk_r  <= walk;
    end
  end

  assign out_tdata = {2'b00, out_walk_r.next_src_y, out_walk_r.next_src_x,
                      out_walk_r.dest_y, out_walk_r.dest_x, out_pixel_r};
  assign out_tlast = out_walk_r.frame_done;

endmodule
